@@ sv/rau_pkg.sv @@
`default_nettype none
package rau_pkg;

    localparam int W     = 32;
    localparam int DW    = 2 * W;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] x;
        logic [DW-1:0] y;
    } t_unit_req;

endpackage
`default_nettype wire

@@ sv/rau_gcd.sv @@
`default_nettype none
module rau_gcd (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rau_pkg::t_unit_req       i_req,
    output logic                          o_done,
    output logic [rau_pkg::DW-1:0]        o_g
);

    localparam int KW = $clog2(rau_pkg::DW);
    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_RUN  = 2'd1;
    localparam logic [1:0] G_SHL  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [rau_pkg::DW-1:0] r_u, n_u, r_v, n_v;
    logic [KW-1:0]          r_k, n_k;

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        o_done  = 1'b0;
        unique case (r_state)
            G_IDLE: begin
                if (i_req.start) begin
                    n_u     = i_req.x;
                    n_v     = i_req.y;
                    n_k     = '0;
                    n_state = G_RUN;
                end
            end
            G_RUN: begin
                if (r_u == r_v) begin
                    n_state = G_SHL;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u > r_v) begin
                    n_u = (r_u - r_v) >> 1;
                end else begin
                    n_v = (r_v - r_u) >> 1;
                end
            end
            G_SHL: begin
                if (r_k == '0) begin
                    o_done  = 1'b1;
                    n_state = G_IDLE;
                end else begin
                    n_u = r_u << 1;
                    n_k = r_k - 1'b1;
                end
            end
            default: n_state = G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_u <= n_u;
        r_v <= n_v;
        r_k <= n_k;
    end

    assign o_g = r_u;

endmodule
`default_nettype wire

@@ sv/rau_div.sv @@
`default_nettype none
module rau_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rau_pkg::t_unit_req       i_req,
    output logic                          o_done,
    output logic [rau_pkg::DW-1:0]        o_q
);

    localparam int CW = $clog2(rau_pkg::DW);

    logic                   r_busy, r_done;
    logic [CW-1:0]          r_cnt;
    logic [rau_pkg::DW-1:0] r_rem, r_quo, r_d;
    logic [rau_pkg::DW:0]   w_sh, w_diff;
    logic                   w_bit;

    always_comb begin
        w_sh   = {r_rem, r_quo[rau_pkg::DW-1]};
        w_diff = w_sh - {1'b0, r_d};
        w_bit  = !w_diff[rau_pkg::DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rau_pkg::DW - 1);
                r_rem  <= '0;
                r_quo  <= i_req.x;
                r_d    <= i_req.y;
            end else if (r_busy) begin
                r_rem <= w_bit ? w_diff[rau_pkg::DW-1:0] : w_sh[rau_pkg::DW-1:0];
                r_quo <= {r_quo[rau_pkg::DW-2:0], w_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_quo;

endmodule
`default_nettype wire

@@ sv/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// fractions, with every arithmetic result reduced to lowest terms.
// Input channel: i_in_valid / o_in_ready carry one beat with the operation
// code and both fractions. Output channel: o_out_valid / i_out_ready carry
// one beat with numerator, denominator, compare order and status.
// Every input beat gives exactly one output beat.
// Invalid codes, zero denominators and divide by zero go from the idle state
// straight to the output state, which loads the output register. Multiply,
// divide and compare run two products on the 32x32 multiplier, add and
// subtract three; arithmetic results then pass one binary gcd and two 64-bit
// shift-subtract divisions. Add and subtract run an extra gcd and two more
// divisions for the lcm first. One item is handled at a time; most of an
// item's time goes to the gcd loop and the bit-serial divider.
// The output register holds a finished beat while the receiver stalls; the
// next input beat is taken meanwhile, but its result waits for that beat.
// Reset (synchronous, active low) drops any item in flight and any
// pending output beat.
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [2:0]                  i_req_type,
    input  wire logic [rau_pkg::NUM_W-1:0]   i_a_num,
    input  wire logic [rau_pkg::DEN_W-1:0]   i_a_den,
    input  wire logic [rau_pkg::NUM_W-1:0]   i_b_num,
    input  wire logic [rau_pkg::DEN_W-1:0]   i_b_den,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [rau_pkg::NUM_W-1:0]        o_res_num,
    output logic [rau_pkg::DEN_W-1:0]        o_res_den,
    output logic [1:0]                       o_order,
    output logic [1:0]                       o_status
);

    localparam int W  = rau_pkg::W;
    localparam int DW = rau_pkg::DW;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_G1   = 5'd1;
    localparam logic [4:0] S_G1W  = 5'd2;
    localparam logic [4:0] S_QA   = 5'd3;
    localparam logic [4:0] S_QAW  = 5'd4;
    localparam logic [4:0] S_QB   = 5'd5;
    localparam logic [4:0] S_QBW  = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_M2   = 5'd8;
    localparam logic [4:0] S_M3   = 5'd9;
    localparam logic [4:0] S_M4   = 5'd10;
    localparam logic [4:0] S_FORM = 5'd11;
    localparam logic [4:0] S_G2   = 5'd12;
    localparam logic [4:0] S_G2W  = 5'd13;
    localparam logic [4:0] S_DN   = 5'd14;
    localparam logic [4:0] S_DNW  = 5'd15;
    localparam logic [4:0] S_DD   = 5'd16;
    localparam logic [4:0] S_DDW  = 5'd17;
    localparam logic [4:0] S_CHK  = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    localparam logic [DW-1:0] LIM_D = DW'((64'd1 << (W - 1)) - 64'd1);

    logic [4:0]    r_state;
    logic [2:0]    r_op;
    logic [W-1:0]  r_an, r_bn;
    logic [W-2:0]  r_ad, r_bd;
    logic [W-1:0]  r_qa, r_qb;
    logic [DW-1:0] r_g, r_prod, r_t1, r_t2, r_nmag, r_den;
    logic          r_neg;
    logic [W-1:0]  r_rnum;
    logic [W-2:0]  r_rden;
    logic [1:0]    r_rord, r_rst;
    logic          r_ovalid;
    logic [W-1:0]  r_onum;
    logic [W-2:0]  r_oden;
    logic [1:0]    r_oord, r_ost;

    logic [W-1:0]  w_in_an, w_in_bn;
    logic [W-2:0]  w_in_ad, w_in_bd;
    logic          w_an_neg, w_bn_neg, w_is_add;
    logic [W-1:0]  w_an_mag, w_bn_mag, w_ma, w_mb;
    logic [DW-1:0] w_prod;
    logic [DW-1:0] w_s1, w_s2, w_sum, w_sum_mag, w_lim_n;
    logic [1:0]    w_cmp;
    logic          w_in_fire, w_out_load;

    rau_pkg::t_unit_req w_greq, w_dreq;
    logic               w_gdone, w_ddone;
    logic [DW-1:0]      w_g, w_q;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_greq),
        .o_done  (w_gdone),
        .o_g     (w_g)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    assign w_in_an   = i_a_num[W-1:0];
    assign w_in_bn   = i_b_num[W-1:0];
    assign w_in_ad   = i_a_den[W-2:0];
    assign w_in_bd   = i_b_den[W-2:0];
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    assign w_an_neg = r_an[W-1];
    assign w_bn_neg = r_bn[W-1];
    assign w_an_mag = w_an_neg ? W'(-r_an) : r_an;
    assign w_bn_mag = w_bn_neg ? W'(-r_bn) : r_bn;
    assign w_is_add = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB);

    always_comb begin
        w_ma = w_an_mag;
        w_mb = {1'b0, r_bd};
        unique case (r_state)
            S_M1: begin
                w_ma = w_an_mag;
                if (w_is_add) begin
                    w_mb = r_qb;
                end else if (r_op == rau_pkg::OP_MUL) begin
                    w_mb = w_bn_mag;
                end else begin
                    w_mb = {1'b0, r_bd};
                end
            end
            S_M2: begin
                if (w_is_add) begin
                    w_ma = w_bn_mag;
                    w_mb = r_qa;
                end else if (r_op == rau_pkg::OP_MUL) begin
                    w_ma = {1'b0, r_ad};
                    w_mb = {1'b0, r_bd};
                end else if (r_op == rau_pkg::OP_DIV) begin
                    w_ma = {1'b0, r_ad};
                    w_mb = w_bn_mag;
                end else begin
                    w_ma = w_bn_mag;
                    w_mb = {1'b0, r_ad};
                end
            end
            S_M3: begin
                w_ma = r_qa;
                w_mb = {1'b0, r_bd};
            end
            default: begin
                w_ma = w_an_mag;
                w_mb = {1'b0, r_bd};
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_s1      = w_an_neg ? -r_t1 : r_t1;
        w_s2      = (w_bn_neg ^ (r_op == rau_pkg::OP_SUB)) ? -r_t2 : r_t2;
        w_sum     = w_s1 + w_s2;
        w_sum_mag = w_sum[DW-1] ? -w_sum : w_sum;
        if ($signed(w_s1) < $signed(w_s2)) begin
            w_cmp = rau_pkg::ORD_LT;
        end else if ($signed(w_s1) > $signed(w_s2)) begin
            w_cmp = rau_pkg::ORD_GT;
        end else begin
            w_cmp = rau_pkg::ORD_EQ;
        end
        w_lim_n = r_neg ? LIM_D + 1'b1 : LIM_D;
    end

    always_comb begin
        w_greq.start = (r_state == S_G1) || (r_state == S_G2);
        w_greq.x     = (r_state == S_G1) ? DW'(r_ad) : r_nmag;
        w_greq.y     = (r_state == S_G1) ? DW'(r_bd) : r_den;
        w_dreq.start = (r_state == S_QA) || (r_state == S_QB) ||
                       (r_state == S_DN) || (r_state == S_DD);
        unique case (r_state)
            S_QA:    w_dreq.x = DW'(r_ad);
            S_QB:    w_dreq.x = DW'(r_bd);
            S_DN:    w_dreq.x = r_nmag;
            default: w_dreq.x = r_den;
        endcase
        w_dreq.y = r_g;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_onum   <= r_rnum;
                r_oden   <= r_rden;
                r_oord   <= r_rord;
                r_ost    <= r_rst;
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_op   <= i_req_type;
                        r_an   <= w_in_an;
                        r_bn   <= w_in_bn;
                        r_ad   <= w_in_ad;
                        r_bd   <= w_in_bd;
                        r_rnum <= '0;
                        r_rden <= (W-1)'(1);
                        r_rord <= rau_pkg::ORD_LT;
                        r_rst  <= rau_pkg::ST_OK;
                        if (i_req_type > rau_pkg::OP_CMP) begin
                            r_state <= S_OUT;
                        end else if (w_in_ad == '0 || w_in_bd == '0) begin
                            r_rst   <= rau_pkg::ST_ZDEN;
                            r_state <= S_OUT;
                        end else if (i_req_type == rau_pkg::OP_DIV && w_in_bn == '0) begin
                            r_rst   <= rau_pkg::ST_DIV0;
                            r_state <= S_OUT;
                        end else if (i_req_type == rau_pkg::OP_ADD ||
                                     i_req_type == rau_pkg::OP_SUB) begin
                            r_state <= S_G1;
                        end else begin
                            r_state <= S_M1;
                        end
                    end
                end
                S_G1:  r_state <= S_G1W;
                S_G1W: begin
                    if (w_gdone) begin
                        r_g     <= w_g;
                        r_state <= S_QA;
                    end
                end
                S_QA:  r_state <= S_QAW;
                S_QAW: begin
                    if (w_ddone) begin
                        r_qa    <= w_q[W-1:0];
                        r_state <= S_QB;
                    end
                end
                S_QB:  r_state <= S_QBW;
                S_QBW: begin
                    if (w_ddone) begin
                        r_qb    <= w_q[W-1:0];
                        r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_t1    <= r_prod;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_t2    <= r_prod;
                    r_state <= w_is_add ? S_M4 : S_FORM;
                end
                S_M4: begin
                    r_den   <= r_prod;
                    r_state <= S_FORM;
                end
                S_FORM: begin
                    if (r_op == rau_pkg::OP_CMP) begin
                        r_rord  <= w_cmp;
                        r_state <= S_OUT;
                    end else if (w_is_add) begin
                        r_nmag  <= w_sum_mag;
                        r_neg   <= w_sum[DW-1];
                        r_state <= (w_sum == '0) ? S_OUT : S_G2;
                    end else begin
                        r_nmag  <= r_t1;
                        r_den   <= r_t2;
                        r_neg   <= w_an_neg ^ w_bn_neg;
                        r_state <= (r_t1 == '0) ? S_OUT : S_G2;
                    end
                end
                S_G2:  r_state <= S_G2W;
                S_G2W: begin
                    if (w_gdone) begin
                        r_g     <= w_g;
                        r_state <= S_DN;
                    end
                end
                S_DN:  r_state <= S_DNW;
                S_DNW: begin
                    if (w_ddone) begin
                        r_nmag  <= w_q;
                        r_state <= S_DD;
                    end
                end
                S_DD:  r_state <= S_DDW;
                S_DDW: begin
                    if (w_ddone) begin
                        r_den   <= w_q;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_nmag > w_lim_n || r_den > LIM_D) begin
                        r_rst <= rau_pkg::ST_OVF;
                    end else begin
                        r_rnum <= r_neg ? W'(-r_nmag) : r_nmag[W-1:0];
                        r_rden <= r_den[W-2:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_res_num   = rau_pkg::NUM_W'($signed(r_onum));
    assign o_res_den   = rau_pkg::DEN_W'(r_oden);
    assign o_order     = r_oord;
    assign o_status    = r_ost;

endmodule
`default_nettype wire

@@ dv/rational_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;

    typedef struct packed {
        logic [2:0]                op;
        logic [rau_pkg::NUM_W-1:0] an;
        logic [rau_pkg::DEN_W-1:0] ad;
        logic [rau_pkg::NUM_W-1:0] bn;
        logic [rau_pkg::DEN_W-1:0] bd;
    } t_req;

    typedef struct packed {
        logic [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0] den;
        logic [1:0]                ord;
        logic [1:0]                st;
    } t_res;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [2:0]                i_req_type = '0;
    logic [rau_pkg::NUM_W-1:0] i_a_num = '0;
    logic [rau_pkg::DEN_W-1:0] i_a_den = '0;
    logic [rau_pkg::NUM_W-1:0] i_b_num = '0;
    logic [rau_pkg::DEN_W-1:0] i_b_den = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [rau_pkg::NUM_W-1:0] o_res_num;
    logic [rau_pkg::DEN_W-1:0] o_res_den;
    logic [1:0]                o_order;
    logic [1:0]                o_status;

    t_res exp_q[$];
    int   errors = 0;
    bit   stim_done = 0;
    bit   hold_start = 0;
    bit   long_hold = 0;

    rational_arithmetic_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] gcd_u(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_res mk(logic signed [63:0] n, logic [63:0] d,
                                logic [1:0] o, logic [1:0] s);
        t_res r;
        r.num = n[rau_pkg::NUM_W-1:0];
        r.den = d[rau_pkg::DEN_W-1:0];
        r.ord = o;
        r.st = s;
        return r;
    endfunction

    function automatic t_res reduce_frac(bit neg, logic [63:0] mag, logic [63:0] den);
        logic [63:0] g;
        logic [63:0] lim_d;
        logic [63:0] lim_n;
        if (mag == 0) return mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK);
        g = gcd_u(mag, den);
        mag = mag / g;
        den = den / g;
        lim_d = 64'h7FFF_FFFF;
        lim_n = neg ? lim_d + 1 : lim_d;
        if (mag > lim_n || den > lim_d) return mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OVF);
        return mk(neg ? -$signed(mag) : $signed(mag), den, rau_pkg::ORD_LT, rau_pkg::ST_OK);
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_res rational_result(t_req q);
        logic signed [63:0] an;
        logic signed [63:0] bn;
        logic signed [63:0] num;
        logic signed [63:0] bt;
        logic signed [63:0] l;
        logic signed [63:0] r;
        logic [63:0] ad;
        logic [63:0] bd;
        logic [63:0] lcm;
        an = $signed(q.an);
        bn = $signed(q.bn);
        ad = q.ad;
        bd = q.bd;
        if (q.op > rau_pkg::OP_CMP) return mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK);
        if (ad == 0 || bd == 0) return mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_ZDEN);
        case (q.op) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                lcm = ad / gcd_u(ad, bd) * bd;
                bt = bn * $signed(lcm / bd);
                if (q.op == rau_pkg::OP_SUB) bt = -bt;
                num = an * $signed(lcm / ad) + bt;
                return reduce_frac(num < 0, abs64(num), lcm);
            end
            rau_pkg::OP_MUL: begin
                num = an * bn;
                return reduce_frac(num < 0, abs64(num), ad * bd);
            end
            rau_pkg::OP_DIV: begin
                if (bn == 0) return mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_DIV0);
                num = an * $signed(bd);
                return reduce_frac((num < 0) != (bn < 0), abs64(num), ad * abs64(bn));
            end
            default: begin
                l = an * $signed(bd);
                r = bn * $signed(ad);
                return mk(0, 1, l < r ? rau_pkg::ORD_LT
                                      : (l > r ? rau_pkg::ORD_GT : rau_pkg::ORD_EQ),
                          rau_pkg::ST_OK);
            end
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        int sel;
        q.op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        sel = $urandom_range(0, 3);
        case (sel)
            0: begin
                q.an = $urandom; q.bn = $urandom;
                q.ad = 31'($urandom); q.bd = 31'($urandom);
            end
            1: begin
                q.an = $signed(32'($urandom_range(0, 40))) - 20;
                q.bn = $signed(32'($urandom_range(0, 40))) - 20;
                q.ad = 31'($urandom_range(1, 30)); q.bd = 31'($urandom_range(1, 30));
            end
            2: begin
                q.an = $signed(32'($urandom_range(0, 200000))) - 100000;
                q.bn = $signed(32'($urandom_range(0, 200000))) - 100000;
                q.ad = 31'($urandom_range(1, 70000)); q.bd = 31'($urandom_range(1, 70000));
            end
            default: begin
                q.an = $urandom; q.bn = $urandom_range(0, 3) == 0 ? 0 : $urandom;
                q.ad = 31'($urandom_range(0, 7) == 0 ? 0 : $urandom);
                q.bd = 31'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 1000));
            end
        endcase
        return q;
    endfunction

    task automatic send_beat(t_req q);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= q.op;
        i_a_num <= q.an;
        i_a_den <= q.ad;
        i_b_num <= q.bn;
        i_b_den <= q.bd;
        do @(posedge i_clk); while (!o_in_ready);
        exp_q.push_back(rational_result(q));
    endtask

    t_row rows[$];

    task automatic add_row(logic [2:0] op, logic [rau_pkg::NUM_W-1:0] an,
                           logic [rau_pkg::DEN_W-1:0] ad,
                           logic [rau_pkg::NUM_W-1:0] bn, logic [rau_pkg::DEN_W-1:0] bd,
                           bit typed, t_res res);
        t_row w;
        w.req = '{op, an, ad, bn, bd};
        w.typed = typed;
        w.res = res;
        rows.push_back(w);
    endtask

    initial begin
        t_res nil;
        nil = '0;
        add_row(rau_pkg::OP_ADD, 1, 2, 1, 3, 0, nil);
        add_row(rau_pkg::OP_SUB, 1, 2, 1, 2, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_MUL, -3, 4, 8, 9, 0, nil);
        add_row(rau_pkg::OP_DIV, 2, 3, -4, 5, 0, nil);
        add_row(rau_pkg::OP_CMP, 1, 2, 2, 4, 1,
                mk(0, 1, rau_pkg::ORD_EQ, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_CMP, -1, 2, 1, 2, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_CMP, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1, 1,
                mk(0, 1, rau_pkg::ORD_GT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_ADD, 1, 0, 1, 1, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_ZDEN));
        add_row(rau_pkg::OP_CMP, 1, 1, 1, 0, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_ZDEN));
        add_row(rau_pkg::OP_DIV, 5, 7, 0, 3, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_DIV0));
        add_row(rau_pkg::OP_ADD, 32'h7FFF_FFFF, 1, 1, 1, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OVF));
        add_row(rau_pkg::OP_SUB, 32'h8000_0000, 1, 1, 1, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OVF));
        add_row(rau_pkg::OP_MUL, 32'h8000_0000, 1, 1, 1, 1,
                mk(32'h8000_0000, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_MUL, 32'h8000_0000, 1, -1, 1, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OVF));
        add_row(rau_pkg::OP_MUL, 1, 31'h7FFF_FFFF, 1, 2, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OVF));
        add_row(rau_pkg::OP_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
                31'h7FFF_FFFF, 1, mk(1, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(3'd5, 3, 4, 5, 6, 1, mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(3'd7, 32'hFFFF_FFFF, 0, 0, 0, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_ADD, 6, 8, 10, 12, 0, nil);
        add_row(rau_pkg::OP_DIV, 0, 5, 3, 7, 1,
                mk(0, 1, rau_pkg::ORD_LT, rau_pkg::ST_OK));
        add_row(rau_pkg::OP_SUB, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h5555_5555,
                31'h2AAA_AAAA, 0, nil);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            send_beat(rows[i].req);
            if (rows[i].typed && exp_q[$] != rows[i].res) begin
                $display("%0t row %0d typed %h predicted %h", $time, i, rows[i].res, exp_q[$]);
                errors++;
            end
        end
        hold_start = 1;
        for (int i = 0; i < 400; i++) begin
            send_beat(rand_req());
            if (i == 200) begin
                i_in_valid <= 1'b0;
                while (exp_q.size() != 0) @(posedge i_clk);
                repeat (30) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        while (!hold_start) @(posedge i_clk);
        long_hold = 1;
        repeat (2000) @(posedge i_clk);
        long_hold = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (exp_q.size() == 0) begin
                    $display("%0t unexpected beat %h/%h ord %0d st %0d", $time,
                             o_res_num, o_res_den, o_order, o_status);
                    errors++;
                end else begin
                    t_res e;
                    e = exp_q.pop_front();
                    if (e.num != o_res_num || e.den != o_res_den
                        || e.ord != o_order || e.st != o_status) begin
                        $display("%0t expected %0d/%0d ord %0d st %0d got %0d/%0d ord %0d st %0d",
                                 $time, $signed(e.num), e.den, e.ord, e.st,
                                 $signed(o_res_num), o_res_den, o_order, o_status);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
            end else if (!i_out_ready || (o_out_valid && i_out_ready)) begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
                if (gap == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (!stim_done || exp_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && exp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
